// ===== hdl/blhl_pkg.sv =====
// Shared constants, types and controller encodings for the battery level history log.
package blhl_pkg;

   localparam int DEPTH   = 64;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int STAMP_W = 32;
   localparam int PCT_W   = 7;
   localparam int MV_W    = 16;
   localparam int MAXC_W  = 7;
   localparam int NUM_W   = MV_W + PCT_W;
   localparam int STEP_W  = $clog2(NUM_W + 1);
   localparam int CSR_IDX_W = 1;

   localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);
   localparam logic [MV_W-1:0] FULL_MV_RESET  = MV_W'(4200);
   localparam logic [MV_W-1:0] EMPTY_MV_RESET = MV_W'(3300);

   localparam logic [CSR_IDX_W-1:0] CSR_FULL_MV  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_MV = CSR_IDX_W'(1);

   localparam logic MODE_RECORD = 1'b0;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [PCT_W-1:0]   pct;
      logic               chg;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIVIDE,
      ST_WRITE,
      ST_FETCH,
      ST_EMIT,
      ST_EMPTY
   } state_type;

   typedef struct packed {
      logic capture;
      logic div_start;
      logic write_entry;
      logic read_init;
      logic fetch;
      logic emit_entry;
      logic emit_empty;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic direct;
      logic read_empty;
      logic last_entry;
      logic div_done;
   } status_type;

endpackage

// ===== hdl/battery_level_history_log_core.sv =====
// Top level of the battery level history log: controller plus datapath.
//
// Channel   Handshake                 Payload
// request   start / busy              req_mode .. req_max_count
// response  rsp_strobe (no stall)     rsp_entry_valid .. rsp_last
// control   csr_valid / csr_ready     csr_index, csr_data
//
// A voltage record waits in ST_DIVIDE for the bit-serial divider (one quotient
// bit per cycle); a gauge record, or one with no span, writes directly.
// A read alternates a fetch from the single registered memory read port with
// the emit of each returned word; an empty read gives its one word.
// Reset clears the write pointer and the fill count and restores the default
// thresholds; the ring memory is never cleared. Results cannot be held off
// by the receiver.
module battery_level_history_log_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_mode,
   input  logic [blhl_pkg::STAMP_W-1:0]   req_now_seconds,
   input  logic                           req_from_gauge,
   input  logic [blhl_pkg::PCT_W-1:0]     req_percent_in,
   input  logic [blhl_pkg::MV_W-1:0]      req_voltage_mv,
   input  logic                           req_charging_in,
   input  logic [blhl_pkg::MAXC_W-1:0]    req_max_count,
   output logic                           rsp_strobe,
   output logic                           rsp_entry_valid,
   output logic [blhl_pkg::MAXC_W-1:0]    rsp_entry_count,
   output logic [blhl_pkg::STAMP_W-1:0]   rsp_age_seconds,
   output logic [blhl_pkg::PCT_W-1:0]     rsp_percent_out,
   output logic                           rsp_charging_out,
   output logic                           rsp_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [blhl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [blhl_pkg::MV_W-1:0]      csr_data
);
   import blhl_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   blhl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   blhl_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_mode         (req_mode),
      .req_now_seconds  (req_now_seconds),
      .req_from_gauge   (req_from_gauge),
      .req_percent_in   (req_percent_in),
      .req_voltage_mv   (req_voltage_mv),
      .req_charging_in  (req_charging_in),
      .req_max_count    (req_max_count),
      .csr_we           (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_entry_count  (rsp_entry_count),
      .rsp_age_seconds  (rsp_age_seconds),
      .rsp_percent_out  (rsp_percent_out),
      .rsp_charging_out (rsp_charging_out),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== hdl/blhl_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
module blhl_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [blhl_pkg::NUM_W-1:0] numer,
   input  logic [blhl_pkg::MV_W-1:0]  denom,
   output logic                      done,
   output logic [blhl_pkg::NUM_W-1:0] quot
);
   import blhl_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic [MV_W-1:0]    rem_ff, rem_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [MV_W-1:0]    den_ff, den_in;
   logic [MV_W:0]      trial;
   logic               fits;

   // The remainder stays below the divisor, so the trial value needs one bit more.
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = numer;
         den_in  = denom;
      end else if (busy_ff) begin
         rem_in = fits ? MV_W'(trial - {1'b0, den_ff}) : MV_W'(trial);
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + STEP_W'(1);
         if (cnt_ff == STEP_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

// ===== hdl/blhl_dp.sv =====
// Datapath: request capture, thresholds, sample ring memory, percent conversion, results.
module blhl_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  blhl_pkg::cmd_type             cmd,
   output blhl_pkg::status_type          status,
   input  logic                          req_mode,
   input  logic [blhl_pkg::STAMP_W-1:0]  req_now_seconds,
   input  logic                          req_from_gauge,
   input  logic [blhl_pkg::PCT_W-1:0]    req_percent_in,
   input  logic [blhl_pkg::MV_W-1:0]     req_voltage_mv,
   input  logic                          req_charging_in,
   input  logic [blhl_pkg::MAXC_W-1:0]   req_max_count,
   input  logic                          csr_we,
   input  logic [blhl_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [blhl_pkg::MV_W-1:0]     csr_data,
   output logic                          rsp_strobe,
   output logic                          rsp_entry_valid,
   output logic [blhl_pkg::MAXC_W-1:0]   rsp_entry_count,
   output logic [blhl_pkg::STAMP_W-1:0]  rsp_age_seconds,
   output logic [blhl_pkg::PCT_W-1:0]    rsp_percent_out,
   output logic                          rsp_charging_out,
   output logic                          rsp_last
);
   import blhl_pkg::*;

   entry_type            mem [DEPTH];
   entry_type            rd_data_ff;

   logic [MV_W-1:0]      full_ff, full_in;
   logic [MV_W-1:0]      empty_ff, empty_in;

   logic                 mode_ff;
   logic [STAMP_W-1:0]   now_ff;
   logic                 gauge_ff;
   logic [PCT_W-1:0]     pin_ff;
   logic [MV_W-1:0]      mv_ff;
   logic                 chg_ff;
   logic [MAXC_W-1:0]    maxc_ff;

   logic [ADDR_W-1:0]    wp_ff, wp_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [ADDR_W-1:0]    rp_ff, rp_in;
   logic [CNT_W-1:0]     remain_ff, remain_in;
   logic [CNT_W-1:0]     n_ff, n_in;

   logic                 strobe_ff;
   logic                 ev_ff;
   logic [MAXC_W-1:0]    cnt_out_ff;
   logic [STAMP_W-1:0]   age_ff;
   logic [PCT_W-1:0]     pct_out_ff;
   logic                 chg_out_ff;
   logic                 last_ff;

   logic [MV_W-1:0]      span;
   logic [MV_W-1:0]      diff;
   logic [NUM_W-1:0]     numer;
   logic [NUM_W-1:0]     quot;
   logic                 div_done;
   logic                 no_span;
   logic [PCT_W-1:0]     pct_wr;
   entry_type            wr_entry;

   logic [MAXC_W-1:0]    fill_ext;
   logic [MAXC_W-1:0]    n_wide;
   logic [CNT_W-1:0]     n_cur;
   logic [ADDR_W-1:0]    oldest;
   logic [CNT_W:0]       start_sum;
   logic [ADDR_W-1:0]    start_ptr;
   logic [STAMP_W-1:0]   age_cur;

   // Thresholds.
   always_comb begin
      full_in  = full_ff;
      empty_in = empty_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FULL_MV:  full_in  = csr_data;
            CSR_EMPTY_MV: empty_in = csr_data;
            default:      full_in  = full_ff;
         endcase
      end
   end

   // Voltage conversion: (mv - empty) * 100 goes through the divider.
   assign span    = full_ff - empty_ff;
   assign diff    = mv_ff - empty_ff;
   assign numer   = (NUM_W'(diff) << 6) + (NUM_W'(diff) << 5) + (NUM_W'(diff) << 2);
   assign no_span = (full_ff <= empty_ff) || (mv_ff <= empty_ff);

   blhl_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (numer),
      .denom (span),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      if (gauge_ff) begin
         pct_wr = (pin_ff > PCT_MAX) ? PCT_MAX : pin_ff;
      end else if (no_span) begin
         pct_wr = '0;
      end else begin
         pct_wr = (quot > NUM_W'(PCT_MAX)) ? PCT_MAX : PCT_W'(quot);
      end
   end

   assign wr_entry.stamp = now_ff;
   assign wr_entry.pct   = pct_wr;
   assign wr_entry.chg   = gauge_ff & chg_ff;

   // Read window: the newest n entries, starting n back from the write pointer.
   assign fill_ext  = MAXC_W'(fill_ff);
   assign n_wide    = (maxc_ff < fill_ext) ? maxc_ff : fill_ext;
   assign n_cur     = CNT_W'(n_wide);
   assign oldest    = (fill_ff == CNT_W'(DEPTH)) ? wp_ff : '0;
   assign start_sum = (CNT_W+1)'(oldest) + (CNT_W+1)'(fill_ff - n_cur);
   assign start_ptr = (start_sum >= (CNT_W+1)'(DEPTH)) ?
                      ADDR_W'(start_sum - (CNT_W+1)'(DEPTH)) : ADDR_W'(start_sum);

   assign age_cur = (now_ff >= rd_data_ff.stamp) ? (now_ff - rd_data_ff.stamp) : '0;

   always_comb begin
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      rp_in     = rp_ff;
      remain_in = remain_ff;
      n_in      = n_ff;
      if (cmd.write_entry) begin
         wp_in = (wp_ff == ADDR_W'(DEPTH - 1)) ? '0 : wp_ff + ADDR_W'(1);
         if (fill_ff != CNT_W'(DEPTH)) begin
            fill_in = fill_ff + CNT_W'(1);
         end
      end
      if (cmd.read_init) begin
         rp_in     = start_ptr;
         remain_in = n_cur;
         n_in      = n_cur;
      end
      if (cmd.emit_entry) begin
         rp_in     = (rp_ff == ADDR_W'(DEPTH - 1)) ? '0 : rp_ff + ADDR_W'(1);
         remain_in = remain_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff   <= FULL_MV_RESET;
         empty_ff  <= EMPTY_MV_RESET;
         wp_ff     <= '0;
         fill_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         full_ff   <= full_in;
         empty_ff  <= empty_in;
         wp_ff     <= wp_in;
         fill_ff   <= fill_in;
         strobe_ff <= cmd.emit_entry | cmd.emit_empty;
      end
      rp_ff     <= rp_in;
      remain_ff <= remain_in;
      n_ff      <= n_in;
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         now_ff   <= req_now_seconds;
         gauge_ff <= req_from_gauge;
         pin_ff   <= req_percent_in;
         mv_ff    <= req_voltage_mv;
         chg_ff   <= req_charging_in;
         maxc_ff  <= req_max_count;
      end
      if (cmd.emit_entry) begin
         ev_ff      <= 1'b1;
         cnt_out_ff <= MAXC_W'(n_ff);
         age_ff     <= age_cur;
         pct_out_ff <= rd_data_ff.pct;
         chg_out_ff <= rd_data_ff.chg;
         last_ff    <= (remain_ff == CNT_W'(1));
      end else if (cmd.emit_empty) begin
         ev_ff      <= 1'b0;
         cnt_out_ff <= '0;
         age_ff     <= '0;
         pct_out_ff <= '0;
         chg_out_ff <= 1'b0;
         last_ff    <= 1'b1;
      end
   end

   // Sample ring: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.write_entry) begin
         mem[wp_ff] <= wr_entry;
      end
      if (cmd.fetch) begin
         rd_data_ff <= mem[rp_ff];
      end
   end

   assign status.is_read    = (mode_ff != MODE_RECORD);
   assign status.direct     = gauge_ff | no_span;
   assign status.read_empty = (n_cur == '0);
   assign status.last_entry = (remain_ff == CNT_W'(1));
   assign status.div_done   = div_done;

   assign rsp_strobe       = strobe_ff;
   assign rsp_entry_valid  = ev_ff;
   assign rsp_entry_count  = cnt_out_ff;
   assign rsp_age_seconds  = age_ff;
   assign rsp_percent_out  = pct_out_ff;
   assign rsp_charging_out = chg_out_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== hdl/blhl_ctrl.sv =====
// Controller state machine sequencing record and read commands.
module blhl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output blhl_pkg::cmd_type    cmd,
   input  blhl_pkg::status_type status
);
   import blhl_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            priority if (status.is_read && status.read_empty) state_in = ST_EMPTY;
            else if (status.is_read)                          state_in = ST_FETCH;
            else if (status.direct)                           state_in = ST_WRITE;
            else                                              state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) state_in = ST_WRITE;
         end
         ST_WRITE: state_in = ST_IDLE;
         ST_FETCH: state_in = ST_EMIT;
         ST_EMIT: begin
            state_in = status.last_entry ? ST_IDLE : ST_FETCH;
         end
         ST_EMPTY: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         ST_DECODE: begin
            cmd.read_init = status.is_read;
            cmd.div_start = !status.is_read && !status.direct;
         end
         ST_DIVIDE: cmd.div_start   = 1'b0;
         ST_WRITE:  cmd.write_entry = 1'b1;
         ST_FETCH:  cmd.fetch       = 1'b1;
         ST_EMIT:   cmd.emit_entry  = 1'b1;
         ST_EMPTY:  cmd.emit_empty  = 1'b1;
         default:   busy            = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
